[rtl/dtw_pkg.sv]
// ----------------------------------------------------------------------------
// dtw_pkg
// Shared types and constants for the DER tag-length-value header walker.
// ----------------------------------------------------------------------------
package dtw_pkg;

  // Offsets and lengths are carried at this width.
  localparam int OFF_W       = 32;
  // Number of containers that may be open at once.
  localparam int STACK_DEPTH = 16;
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);

  // Identifier and length octet masks.
  localparam logic [7:0] TAG_NUM_MASK = 8'h1F;
  localparam logic [7:0] LEN_LONG     = 8'h80;
  localparam logic [7:0] LEN_NUM_MASK = 8'h7F;
  localparam logic [6:0] LEN_MAX_OCT  = 7'd8;

  typedef enum logic [2:0] {
    PH_TAG       = 3'd0,
    PH_SKIP      = 3'd1,
    PH_LEN_FIRST = 3'd2,
    PH_LEN_BYTES = 3'd3,
    PH_CONTENT   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    EV_HEADER = 2'd0,
    EV_DONE   = 2'd1,
    EV_ERROR  = 2'd2
  } evt_kind_t;

  typedef enum logic [2:0] {
    ERR_TRUNCATED  = 3'd0,
    ERR_INDEFINITE = 3'd1,
    ERR_TOO_WIDE   = 3'd2,
    ERR_OVERRUN    = 3'd3,
    ERR_TOO_DEEP   = 3'd4
  } err_code_t;

  // A byte as classified by the front end.
  typedef struct packed {
    logic [7:0] data;
    logic       sof;
    logic       high_tag;
    logic       cons;
    logic       short_len;
    logic       indef;
    logic       too_wide;
    logic [3:0] num;
  } byte_cls_t;

endpackage

[rtl/dtw_front.sv]
// ----------------------------------------------------------------------------
// dtw_front
// Accepts message bytes, classifies each one and holds it in a two-entry
// queue for the walker.
// ----------------------------------------------------------------------------
module dtw_front import dtw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [7:0] in_data_byte,
  input  logic      in_start_of_message,
  output logic      q_valid,
  input  logic      q_ready,
  output byte_cls_t q_item
);

  byte_cls_t  cls;
  byte_cls_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  // Decode the byte for every phase it might be used in.
  always_comb begin
    cls.data      = in_data_byte;
    cls.sof       = in_start_of_message;
    cls.high_tag  = (in_data_byte & TAG_NUM_MASK) == TAG_NUM_MASK;
    cls.cons      = in_data_byte[5];
    cls.short_len = in_data_byte < LEN_LONG;
    cls.indef     = in_data_byte == LEN_LONG;
    cls.too_wide  = (in_data_byte[6:0] & LEN_NUM_MASK[6:0]) > LEN_MAX_OCT;
    cls.num       = in_data_byte[3:0];
  end

  assign in_ready = cnt_r != 2'd2;
  assign q_valid  = cnt_r != 2'd0;
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 && !pop |=> cnt_r == 2'd2) else $error("queue count lost");
  a_ptr_diff: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 || cnt_r == 2'd2 |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");
`endif

endmodule

[rtl/dtw_back.sv]
// ----------------------------------------------------------------------------
// dtw_back
// Walks the tag-length-value structure one classified byte per cycle unless a
// result waits on out_ready, keeps the container end stack, registers the result.
// ----------------------------------------------------------------------------
module dtw_back import dtw_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [OFF_W-1:0] msg_len,
  input  logic             q_valid,
  output logic             q_ready,
  input  byte_cls_t        q_item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_event_res,
  output logic [2:0]       out_error_code,
  output logic [7:0]       out_tag_byte,
  output logic [31:0]      out_element_length,
  output logic [4:0]       out_nesting_depth,
  output logic [31:0]      out_header_offset,
  output logic             out_is_constructed,
  output logic             out_message_done
);

  // Walk state.
  phase_t           ph_r, ph_nxt;
  logic [OFF_W-1:0] pos_r, pos_nxt;
  logic [7:0]       tag_r, tag_nxt;
  logic [OFF_W-1:0] acc_r, acc_nxt;
  logic             ovf_r, ovf_nxt;
  logic [3:0]       lbl_r, lbl_nxt;
  logic [OFF_W-1:0] cbl_r, cbl_nxt;
  logic [OFF_W-1:0] est_r, est_nxt;
  logic [SP_W-1:0]  sp_r, sp_nxt;
  logic             fin_r, fin_nxt;
  logic             fail_r, fail_nxt;
  logic [OFF_W-1:0] stack_r [STACK_DEPTH];

  // Result register.
  logic             ov_r, ov_nxt;
  evt_kind_t        ev_r, ev_nxt;
  err_code_t        ec_r, ec_nxt;
  logic [7:0]       otag_r, otag_nxt;
  logic [OFF_W-1:0] olen_r, olen_nxt;
  logic [SP_W-1:0]  odep_r, odep_nxt;
  logic [OFF_W-1:0] ooff_r, ooff_nxt;
  logic             ocons_r, ocons_nxt;
  logic             odone_r, odone_nxt;

  // Working values.
  logic                   take, emit;
  phase_t                 c_ph;
  logic [OFF_W-1:0]       c_pos, pos_inc, bound, avail;
  logic [SP_W-1:0]        c_sp, pops;
  logic                   c_fin, c_fail;
  logic [STACK_DEPTH-1:0] hit;
  logic                   push;
  logic [OFF_W-1:0]       push_val;
  logic                   hdr_go, hdr_ovf, err;
  logic [OFF_W-1:0]       hdr_len, acc_sh;
  err_code_t              err_code;

  assign q_ready = !ov_r || out_ready;
  assign take    = q_valid && q_ready;

  // Start of message clears the walk before the byte is used.
  always_comb begin
    c_ph    = q_item.sof ? PH_TAG : ph_r;
    c_pos   = q_item.sof ? '0 : pos_r;
    c_sp    = q_item.sof ? '0 : sp_r;
    c_fin   = q_item.sof ? 1'b0 : fin_r;
    c_fail  = q_item.sof ? 1'b0 : fail_r;
    bound   = (c_sp != '0) ? stack_r[IDX_W'(c_sp - SP_W'(1))] : msg_len;
    pos_inc = c_pos + OFF_W'(1);
    avail   = bound - pos_inc;
    acc_sh  = {acc_r[OFF_W-9:0], q_item.data};
  end

  // Parallel check of the open containers that end at the new position.
  always_comb begin
    for (int k = 0; k < STACK_DEPTH; k++) begin
      hit[k] = (SP_W'(k) < c_sp) && (stack_r[k] <= pos_inc);
    end
    pops = SP_W'($countones(hit));
  end

  // Walk step.
  always_comb begin
    ph_nxt   = c_ph;
    pos_nxt  = c_pos;
    tag_nxt  = tag_r;
    acc_nxt  = acc_r;
    ovf_nxt  = ovf_r;
    lbl_nxt  = lbl_r;
    cbl_nxt  = cbl_r;
    est_nxt  = est_r;
    sp_nxt   = c_sp;
    fin_nxt  = c_fin;
    fail_nxt = c_fail;
    push     = 1'b0;
    push_val = pos_inc;
    hdr_go   = 1'b0;
    hdr_len  = '0;
    hdr_ovf  = 1'b0;
    err      = 1'b0;
    err_code = ERR_TRUNCATED;
    emit     = 1'b0;
    ev_nxt   = EV_HEADER;
    ec_nxt   = ERR_TRUNCATED;
    otag_nxt = '0;
    olen_nxt = '0;
    odep_nxt = '0;
    ooff_nxt = '0;
    ocons_nxt = 1'b0;
    odone_nxt = 1'b0;

    if (c_fin || c_fail) begin
      // Walk over: byte ignored.
    end else if (c_ph == PH_CONTENT) begin
      pos_nxt = pos_inc;
      cbl_nxt = cbl_r - OFF_W'(1);
      if (cbl_r == OFF_W'(1)) begin
        sp_nxt = c_sp - pops;
        ph_nxt = PH_TAG;
        if (sp_nxt == '0) begin
          fin_nxt   = 1'b1;
          emit      = 1'b1;
          ev_nxt    = EV_DONE;
          odone_nxt = 1'b1;
        end
      end
    end else if (c_pos >= bound) begin
      err = 1'b1;
    end else begin
      pos_nxt = pos_inc;
      case (c_ph)
        PH_TAG: begin
          est_nxt = c_pos;
          tag_nxt = q_item.data;
          ph_nxt  = q_item.high_tag ? PH_SKIP : PH_LEN_FIRST;
        end
        PH_SKIP: begin
          if (!q_item.data[7]) begin
            ph_nxt = PH_LEN_FIRST;
          end
        end
        PH_LEN_FIRST: begin
          if (q_item.short_len) begin
            hdr_go  = 1'b1;
            hdr_len = OFF_W'(q_item.data);
          end else if (q_item.indef) begin
            err      = 1'b1;
            err_code = ERR_INDEFINITE;
          end else if (q_item.too_wide) begin
            err      = 1'b1;
            err_code = ERR_TOO_WIDE;
          end else if (OFF_W'(q_item.num) > avail) begin
            err = 1'b1;
          end else begin
            lbl_nxt = q_item.num;
            acc_nxt = '0;
            ovf_nxt = 1'b0;
            ph_nxt  = PH_LEN_BYTES;
          end
        end
        PH_LEN_BYTES: begin
          // Bits shifted above the offset width only matter as overrun.
          acc_nxt = acc_sh;
          ovf_nxt = ovf_r || (acc_r[OFF_W-1:OFF_W-8] != 8'd0);
          lbl_nxt = lbl_r - 4'd1;
          if (lbl_r == 4'd1) begin
            hdr_go  = 1'b1;
            hdr_len = acc_sh;
            hdr_ovf = ovf_nxt;
          end
        end
        default: begin
          ph_nxt = PH_TAG;
        end
      endcase

      // Header complete: check bounds and depth, then report it.
      if (hdr_go) begin
        if (hdr_ovf || (hdr_len > avail)) begin
          err      = 1'b1;
          err_code = ERR_OVERRUN;
        end else if (tag_r[5] && (c_sp >= SP_W'(STACK_DEPTH))) begin
          err      = 1'b1;
          err_code = ERR_TOO_DEEP;
        end else begin
          if (tag_r[5]) begin
            push     = 1'b1;
            push_val = pos_inc + hdr_len;
            ph_nxt   = PH_TAG;
            if (hdr_len == '0) begin
              // The new container closes at once, with any it ends.
              sp_nxt = c_sp - pops;
            end else begin
              sp_nxt = c_sp + SP_W'(1);
            end
          end else if (hdr_len == '0) begin
            sp_nxt = c_sp - pops;
            ph_nxt = PH_TAG;
          end else begin
            cbl_nxt = hdr_len;
            ph_nxt  = PH_CONTENT;
          end
          if ((tag_r[5] || hdr_len == '0) && sp_nxt == '0) begin
            fin_nxt = 1'b1;
          end
          emit      = 1'b1;
          ev_nxt    = EV_HEADER;
          otag_nxt  = tag_r;
          olen_nxt  = hdr_len;
          odep_nxt  = c_sp;
          ooff_nxt  = est_r;
          ocons_nxt = tag_r[5];
          odone_nxt = fin_nxt;
        end
      end else if (!err && (pos_inc >= bound)) begin
        err = 1'b1;
      end
    end

    if (err) begin
      fail_nxt  = 1'b1;
      push      = 1'b0;
      emit      = 1'b1;
      ev_nxt    = EV_ERROR;
      ec_nxt    = err_code;
      otag_nxt  = '0;
      olen_nxt  = '0;
      odep_nxt  = '0;
      ooff_nxt  = '0;
      ocons_nxt = 1'b0;
      odone_nxt = 1'b0;
    end
  end

  assign ov_nxt = (take && emit) ? 1'b1 : (out_ready ? 1'b0 : ov_r);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_TAG;
      pos_r  <= '0;
      sp_r   <= '0;
      fin_r  <= 1'b0;
      fail_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (take) begin
        ph_r   <= ph_nxt;
        pos_r  <= pos_nxt;
        sp_r   <= sp_nxt;
        fin_r  <= fin_nxt;
        fail_r <= fail_nxt;
      end
    end
  end

  // Payload state and container end stack.
  always_ff @(posedge clk) begin
    if (take) begin
      tag_r <= tag_nxt;
      acc_r <= acc_nxt;
      ovf_r <= ovf_nxt;
      lbl_r <= lbl_nxt;
      cbl_r <= cbl_nxt;
      est_r <= est_nxt;
      if (push) begin
        stack_r[c_sp[IDX_W-1:0]] <= push_val;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (take && emit) begin
      ev_r    <= ev_nxt;
      ec_r    <= ec_nxt;
      otag_r  <= otag_nxt;
      olen_r  <= olen_nxt;
      odep_r  <= odep_nxt;
      ooff_r  <= ooff_nxt;
      ocons_r <= ocons_nxt;
      odone_r <= odone_nxt;
    end
  end

  assign out_valid          = ov_r;
  assign out_event_res      = ev_r;
  assign out_error_code     = ec_r;
  assign out_tag_byte       = otag_r;
  assign out_element_length = olen_r;
  assign out_nesting_depth  = 5'(odep_r);
  assign out_header_offset  = ooff_r;
  assign out_is_constructed = ocons_r;
  assign out_message_done   = odone_r;

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH)) else $error("stack pointer past depth");
  a_idle_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    take && !q_item.sof && (fin_r || fail_r) |-> !emit)
    else $error("transaction produced after walk ended");
  a_content_count: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r == PH_CONTENT |-> cbl_r != '0) else $error("content phase with no bytes left");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |-> !take) else $error("result register overwritten");
`endif

endmodule

[rtl/der_tlv_header_walker.sv]
// A result is registered in the walker's result register after its byte has
// passed through the two-entry queue, and is held there until out_ready takes it.
// Throughput: one byte per cycle unless a result waits on out_ready; one byte's
// compares, length shift and parallel stack check are all combinational.
// A two-entry queue parts byte intake from the walker, and the result
// register parts the walker from the output side.
// Reset (rst_n low, synchronous) clears the walk, the queue and message_length.
// ----------------------------------------------------------------------------
// der_tlv_header_walker
// Top level: message length register, byte classifier with queue, and walker.
// ----------------------------------------------------------------------------
module der_tlv_header_walker import dtw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [31:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_res,
  output logic [2:0]  out_error_code,
  output logic [7:0]  out_tag_byte,
  output logic [31:0] out_element_length,
  output logic [4:0]  out_nesting_depth,
  output logic [31:0] out_header_offset,
  output logic        out_is_constructed,
  output logic        out_message_done
);

  logic [OFF_W-1:0] msg_len_r, msg_len_nxt;
  logic             q_valid, q_ready;
  byte_cls_t        q_item;

  // Message length register.
  assign msg_len_nxt = cfg_write_en ? OFF_W'(cfg_write_data) : msg_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_len_r <= '0;
    end else begin
      msg_len_r <= msg_len_nxt;
    end
  end

  dtw_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_start_of_message (in_start_of_message),
    .q_valid             (q_valid),
    .q_ready             (q_ready),
    .q_item              (q_item)
  );

  dtw_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .msg_len            (msg_len_r),
    .q_valid            (q_valid),
    .q_ready            (q_ready),
    .q_item             (q_item),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_res      (out_event_res),
    .out_error_code     (out_error_code),
    .out_tag_byte       (out_tag_byte),
    .out_element_length (out_element_length),
    .out_nesting_depth  (out_nesting_depth),
    .out_header_offset  (out_header_offset),
    .out_is_constructed (out_is_constructed),
    .out_message_done   (out_message_done)
  );

endmodule
